/* design/stew_pkg.sv */
// Shared constants for the short-time energy weight block.
package stew_pkg;

    localparam int SUM_W           = 36;
    localparam int ORDER_W         = 6;
    localparam int OUT_TDATA_W     = 40;
    localparam int DEF_MAX_ORDER   = 63;
    localparam int DEF_SAMPLE_BITS = 16;

    localparam logic [ORDER_W-1:0] ORDER_RESET = 6'd30;

endpackage

/* design/short_time_energy_weight.sv */
// Short-time energy weight: windowed sum of squared previous samples per position.
//
// Usage:
//   s_* stream carries one sample per item, s_tlast marks the last sample of a frame.
//   m_* stream carries one weight per item, m_tlast marks the final weight of a frame.
//   cfg_* writes the window order; it is always ready and should be written while idle.
// Each sample gives the weight of its own position (the sum of the previous order
// squares, or 1 when that sum is zero). The frame's last sample also gives order more
// weights, one per cycle when not stalled, then the window and the sum clear.
// A sample is registered in the input stage, then its weight in the output stage.
// The input takes one sample per cycle outside a flush and a stall; a frame of N
// samples gives N + order weights, one weight per cycle when not stalled.
// The square is taken in the input stage, the window add/subtract in the output stage.
// The window sits in a ring memory; the leaving square is registered before its push; a
// fill count masks slots not yet written in the frame, so no clearing pass is needed.
// Reset clears the fill count, the sum and both pipeline stages, and loads order 30.
// When m_tready is low the output item holds, the input stage fills and s_tready drops.
module short_time_energy_weight #(
    parameter int MAX_ORDER   = stew_pkg::DEF_MAX_ORDER,
    parameter int SAMPLE_BITS = stew_pkg::DEF_SAMPLE_BITS
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]   s_tdata,    // sample
    input  logic                               s_tlast,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [stew_pkg::OUT_TDATA_W-1:0]   m_tdata,    // weight, zero pad
    output logic                               m_tlast,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [stew_pkg::ORDER_W-1:0]       cfg_data
);

    localparam int SUM_W   = stew_pkg::SUM_W;
    localparam int ORDER_W = stew_pkg::ORDER_W;
    localparam int IDX_W   = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
    localparam int SQ_W    = (2*SAMPLE_BITS-1 < SUM_W) ? 2*SAMPLE_BITS-1 : SUM_W;

    logic [ORDER_W-1:0]     order_reg, order_next;
    logic                   v1_reg, v1_next;
    logic [SQ_W-1:0]        sq1_reg, sq1_next;
    logic                   end1_reg, end1_next;
    logic [ORDER_W-1:0]     cnt_reg, cnt_next;
    logic [SUM_W-1:0]       sum_reg, sum_next;
    logic [IDX_W-1:0]       ptr_reg, ptr_next;
    logic [ORDER_W-1:0]     fill_reg, fill_next;
    logic [SQ_W-1:0]        rd_data_reg;
    logic [SQ_W-1:0]        ring_mem [MAX_ORDER];
    logic                   out_valid_reg, out_valid_next;
    logic [SUM_W-1:0]       weight_reg, weight_next;
    logic                   last_reg, last_next;

    logic [SAMPLE_BITS-1:0]   raw;
    logic [SAMPLE_BITS-1:0]   mag;
    logic [2*SAMPLE_BITS-1:0] prod;
    logic [ORDER_W-1:0]       order_m;
    logic [ORDER_W-1:0]       order_m_next;
    logic [IDX_W:0]           rd_sum;
    logic [IDX_W-1:0]         rd_addr;
    logic [SQ_W-1:0]          push_val;
    logic [SQ_W-1:0]          leave_val;
    logic                     out_free, flushing, do_flush, take1, do_push, clear, mem_we;

    function automatic logic [ORDER_W-1:0] limit_order(input logic [ORDER_W-1:0] o);
        logic [ORDER_W-1:0] m;
        if (o == '0)
        begin
            m = ORDER_W'(1);
        end
        else if (o > ORDER_W'(MAX_ORDER))
        begin
            m = ORDER_W'(MAX_ORDER);
        end
        else
        begin
            m = o;
        end
        return m;
    endfunction

    // input stage: magnitude and square
    assign raw  = s_tdata[SAMPLE_BITS-1:0];
    assign mag  = raw[SAMPLE_BITS-1] ? (~raw + SAMPLE_BITS'(1)) : raw;
    assign prod = {{SAMPLE_BITS{1'b0}}, mag} * {{SAMPLE_BITS{1'b0}}, mag};

    assign order_next   = (cfg_valid && cfg_ready) ? cfg_data : order_reg;
    assign order_m      = limit_order(order_reg);
    assign order_m_next = limit_order(order_next);

    // leaving square exists only once order pushes have landed in this frame
    assign leave_val = (fill_reg >= order_m) ? rd_data_reg : '0;

    assign out_free  = !out_valid_reg || m_tready;
    assign flushing  = (cnt_reg != '0);
    assign do_flush  = out_free && flushing;
    assign take1     = out_free && !flushing && v1_reg;
    assign do_push   = do_flush || take1;
    assign clear     = do_flush && (cnt_reg == ORDER_W'(1));
    assign push_val  = take1 ? sq1_reg : '0;
    assign mem_we    = do_push && !clear;

    assign s_tready  = !v1_reg || take1;
    assign cfg_ready = 1'b1;

    always_comb
    begin
        v1_next   = v1_reg;
        sq1_next  = sq1_reg;
        end1_next = end1_reg;
        if (s_tready)
        begin
            v1_next   = s_tvalid;
            sq1_next  = prod[SQ_W-1:0];
            end1_next = s_tlast;
        end

        cnt_next = cnt_reg;
        if (do_flush)
        begin
            cnt_next = cnt_reg - ORDER_W'(1);
        end
        else if (take1 && end1_reg)
        begin
            cnt_next = order_m;
        end

        sum_next  = sum_reg;
        ptr_next  = ptr_reg;
        fill_next = fill_reg;
        if (clear)
        begin
            sum_next  = '0;
            ptr_next  = '0;
            fill_next = '0;
        end
        else if (do_push)
        begin
            sum_next = sum_reg + SUM_W'(push_val) - SUM_W'(leave_val);
            if (ptr_reg == IDX_W'(MAX_ORDER - 1))
            begin
                ptr_next = '0;
            end
            else
            begin
                ptr_next = ptr_reg + IDX_W'(1);
            end
            if (fill_reg < ORDER_W'(MAX_ORDER))
            begin
                fill_next = fill_reg + ORDER_W'(1);
            end
        end

        // slot that leaves the window on the next push
        rd_sum = {1'b0, ptr_next} + (IDX_W+1)'(MAX_ORDER) - (IDX_W+1)'(order_m_next);
        if (rd_sum >= (IDX_W+1)'(MAX_ORDER))
        begin
            rd_addr = IDX_W'(rd_sum - (IDX_W+1)'(MAX_ORDER));
        end
        else
        begin
            rd_addr = IDX_W'(rd_sum);
        end

        out_valid_next = out_valid_reg;
        weight_next    = weight_reg;
        last_next      = last_reg;
        if (out_free)
        begin
            out_valid_next = do_push;
            weight_next    = (sum_reg == '0) ? SUM_W'(1) : sum_reg;
            last_next      = clear;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            order_reg     <= stew_pkg::ORDER_RESET;
            v1_reg        <= 1'b0;
            cnt_reg       <= '0;
            sum_reg       <= '0;
            ptr_reg       <= '0;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            order_reg     <= order_next;
            v1_reg        <= v1_next;
            cnt_reg       <= cnt_next;
            sum_reg       <= sum_next;
            ptr_reg       <= ptr_next;
            fill_reg      <= fill_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            ring_mem[ptr_reg] <= push_val;
        end
        rd_data_reg <= (mem_we && (rd_addr == ptr_reg)) ? push_val : ring_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        sq1_reg    <= sq1_next;
        end1_reg   <= end1_next;
        weight_reg <= weight_next;
        last_reg   <= last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(stew_pkg::OUT_TDATA_W-SUM_W){1'b0}}, weight_reg};
    assign m_tlast  = last_reg;

endmodule

/* design/stew_checker.sv */
// Port-level assertions for the short-time energy weight block, with its bind.
module stew_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             s_tvalid,
    input logic                             s_tready,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [stew_pkg::OUT_TDATA_W-1:0] m_tdata,
    input logic                             m_tlast
);

    localparam int SUM_W = stew_pkg::SUM_W;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output item changed while stalled");

    a_weight_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[SUM_W-1:0] != '0)
        else $error("weight of zero");

    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[stew_pkg::OUT_TDATA_W-1:SUM_W] == '0)
        else $error("tdata pad bits not zero");

    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready && $past(m_tvalid && !m_tready)
            && $past(s_tvalid && s_tready) |-> !s_tready)
        else $error("input stage took a second item under a stalled output");

endmodule

bind short_time_energy_weight stew_checker u_stew_checker (.*);

/* sim/testbench.sv */
// Stream-level testbench for the short-time energy weight block with a built-in weight predictor.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SUM_W       = stew_pkg::SUM_W;
    localparam int ORDER_W     = stew_pkg::ORDER_W;
    localparam int OUT_TDATA_W = stew_pkg::OUT_TDATA_W;
    localparam int WIN_DEPTH   = stew_pkg::DEF_MAX_ORDER;
    localparam int SMP_W       = ((stew_pkg::DEF_SAMPLE_BITS + 7) / 8) * 8;
    localparam int RAND_ITEMS  = 290;
    localparam int QUIET_TAIL  = 40;
    localparam int N_ROWS      = 22;

    typedef struct packed {
        logic [SUM_W-1:0] weight;
        logic             last;
    } weight_t;

    typedef struct packed {
        logic             known;
        logic [SUM_W-1:0] weight;
    } typed_t;

    typedef struct packed {
        logic               set_order;
        logic [ORDER_W-1:0] order;
        logic [SMP_W-1:0]   sample;
        logic               frame_end;
        logic               known;
        logic [SUM_W-1:0]   weight;
    } row_t;

    logic                   clk;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [SMP_W-1:0]       s_tdata;
    logic                   s_tlast;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   m_tlast;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [ORDER_W-1:0]     cfg_data;

    short_time_energy_weight dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // energy predictor state
    logic [SUM_W-1:0]   sq_ring [WIN_DEPTH];
    int unsigned        ring_wr;
    logic [SUM_W-1:0]   win_sum;
    logic [ORDER_W-1:0] order_reg;

    weight_t weight_q[$];
    typed_t  typed_q[$];
    int      err_count = 0;
    bit      src_idle  = 1'b0;
    bit      snk_idle  = 1'b0;
    int      stall_left = 0;

    row_t rows [N_ROWS] = '{
        '{1'b0, 6'd0,  16'h0000, 1'b0, 1'b1, 36'd1},
        '{1'b0, 6'd0,  16'h8000, 1'b0, 1'b1, 36'd1},
        '{1'b0, 6'd0,  16'h7FFF, 1'b0, 1'b1, 36'd1073741824},
        '{1'b0, 6'd0,  16'hFFFF, 1'b0, 1'b1, 36'd2147418113},
        '{1'b0, 6'd0,  16'h0001, 1'b1, 1'b1, 36'd2147418114},
        '{1'b1, 6'd1,  16'h0005, 1'b0, 1'b1, 36'd1},
        '{1'b0, 6'd0,  16'hFFFD, 1'b0, 1'b1, 36'd25},
        '{1'b0, 6'd0,  16'h0000, 1'b0, 1'b1, 36'd9},
        '{1'b0, 6'd0,  16'h0007, 1'b1, 1'b1, 36'd1},
        '{1'b1, 6'd63, 16'h8000, 1'b0, 1'b1, 36'd1},
        '{1'b0, 6'd0,  16'h8000, 1'b0, 1'b1, 36'd1073741824},
        '{1'b0, 6'd0,  16'h7FFF, 1'b0, 1'b1, 36'd2147483648},
        '{1'b0, 6'd0,  16'h8000, 1'b0, 1'b1, 36'd3221159937},
        '{1'b0, 6'd0,  16'h8000, 1'b1, 1'b1, 36'd4294901761},
        '{1'b1, 6'd0,  16'h0002, 1'b0, 1'b1, 36'd1},
        '{1'b0, 6'd0,  16'h0003, 1'b0, 1'b1, 36'd4},
        '{1'b0, 6'd0,  16'h0004, 1'b1, 1'b1, 36'd9},
        '{1'b1, 6'd4,  16'h000A, 1'b0, 1'b1, 36'd1},
        '{1'b0, 6'd0,  16'h0014, 1'b0, 1'b1, 36'd100},
        '{1'b0, 6'd0,  16'h001E, 1'b0, 1'b1, 36'd500},
        '{1'b1, 6'd2,  16'h0028, 1'b0, 1'b0, 36'd0},   // order change mid-frame
        '{1'b0, 6'd0,  16'hFFD8, 1'b1, 1'b0, 36'd0}
    };

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #10ms;
        $display("Mismatches found");
        $finish;
    end

    task automatic note_mismatch(input string msg);
        $display("ERROR at %0t: %s", $realtime, msg);
        err_count++;
    endtask

    function automatic int unsigned active_order();
        if (order_reg == '0)
            return 1;
        if (order_reg > WIN_DEPTH)
            return WIN_DEPTH;
        return 32'(order_reg);
    endfunction

    function automatic logic [SUM_W-1:0] current_weight();
        return (win_sum == '0) ? SUM_W'(1) : win_sum;
    endfunction

    task automatic slide_window(input logic [SUM_W-1:0] sq, input int unsigned m);
        int unsigned out_slot;
        out_slot = (ring_wr + WIN_DEPTH - m) % WIN_DEPTH;
        win_sum = win_sum + sq - sq_ring[out_slot];
        sq_ring[ring_wr] = sq;
        ring_wr = (ring_wr + 1) % WIN_DEPTH;
    endtask

    task automatic clear_window();
        foreach (sq_ring[i])
            sq_ring[i] = '0;
        ring_wr = 0;
        win_sum = '0;
    endtask

    task automatic predict_weights(input logic [SMP_W-1:0] raw, input logic fe,
                                   input typed_t typed);
        logic [SMP_W-1:0] mag;
        logic [SUM_W-1:0] sq;
        int unsigned      m;
        m   = active_order();
        mag = raw[SMP_W-1] ? (~raw + 1'b1) : raw;
        sq  = SUM_W'(mag) * SUM_W'(mag);
        weight_q.push_back('{typed.known ? typed.weight : current_weight(), 1'b0});
        slide_window(sq, m);
        if (fe)
        begin
            for (int unsigned f = 0; f < m; f++)
            begin
                weight_q.push_back('{current_weight(), (f + 1 == m)});
                slide_window('0, m);
            end
            clear_window();
        end
    endtask

    // predictor and checker; pre-edge values are sampled at each rising edge
    always @(posedge clk or negedge rst_n)
    begin
        weight_t exp_w;
        typed_t  typed;
        if (!rst_n)
        begin
            clear_window();
            order_reg = stew_pkg::ORDER_RESET;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                order_reg = cfg_data;
            if (s_tvalid && s_tready)
            begin
                typed = (typed_q.size() != 0) ? typed_q.pop_front() : '0;
                predict_weights(s_tdata, s_tlast, typed);
            end
            if (m_tvalid && m_tready)
            begin
                if (weight_q.size() == 0)
                    note_mismatch($sformatf("unexpected weight %0d last %0b",
                                            m_tdata[SUM_W-1:0], m_tlast));
                else
                begin
                    exp_w = weight_q.pop_front();
                    if (m_tdata[SUM_W-1:0] !== exp_w.weight)
                        note_mismatch($sformatf("weight got %0d want %0d",
                                                m_tdata[SUM_W-1:0], exp_w.weight));
                    if (m_tlast !== exp_w.last)
                        note_mismatch($sformatf("last_weight got %0b want %0b",
                                                m_tlast, exp_w.last));
                end
            end
        end
    end

    // output backpressure in bursts
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready   <= 1'b0;
            stall_left <= 0;
        end
        else if (stall_left > 0)
        begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if (snk_idle && $urandom_range(0, 5) == 0)
        begin
            m_tready   <= 1'b0;
            stall_left <= $urandom_range(0, 4);
        end
        else
            m_tready <= 1'b1;
    end

    task automatic send_sample(input logic [SMP_W-1:0] smp, input logic fe, input typed_t typed);
        if (src_idle && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        typed_q.push_back(typed);
        s_tvalid <= 1'b1;
        s_tdata  <= smp;
        s_tlast  <= fe;
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (weight_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_order(input logic [ORDER_W-1:0] val);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [SMP_W-1:0] pick_sample(input bit loud);
        if (loud)
            return 16'h8000;
        case ($urandom_range(0, 9))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            3: return 16'hFFFF;
            4: return 16'h0001;
            default: return SMP_W'($urandom_range(0, 65535));
        endcase
    endfunction

    initial
    begin
        int                 sent;
        int                 frame_left;
        int                 phase_len;
        bit                 loud;
        logic [ORDER_W-1:0] ord;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tlast   <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_data  <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        src_idle = 1'b1;
        snk_idle = 1'b1;
        foreach (rows[i])
        begin
            if (rows[i].set_order)
                write_order(rows[i].order);
            send_sample(rows[i].sample, rows[i].frame_end, '{rows[i].known, rows[i].weight});
        end

        sent       = 0;
        frame_left = 0;
        loud       = 1'b0;
        while (sent < RAND_ITEMS)
        begin
            case ($urandom_range(0, 5))
                0: ord = 6'd1;
                1: ord = 6'd63;
                2: ord = 6'd0;
                default: ord = ORDER_W'($urandom_range(1, 63));
            endcase
            write_order(ord);
            src_idle  = ($urandom_range(0, 3) != 0);
            snk_idle  = ($urandom_range(0, 3) != 0);
            phase_len = $urandom_range(8, 40);
            repeat (phase_len)
            begin
                if (sent >= RAND_ITEMS - QUIET_TAIL)
                begin
                    src_idle = 1'b0;
                    snk_idle = 1'b0;
                end
                if (frame_left == 0)
                begin
                    frame_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 75)
                                                              : $urandom_range(1, 12);
                    loud = ($urandom_range(0, 5) == 0);
                end
                frame_left--;
                send_sample(pick_sample(loud), frame_left == 0, '0);
                sent++;
            end
        end

        wait_drained();
        repeat (10) @(posedge clk);
        if (err_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

/* filelist.f */
design/stew_pkg.sv
design/short_time_energy_weight.sv
design/stew_checker.sv
sim/testbench.sv
